// File: rtl/ssg_pkg.sv
package ssg_pkg;
  localparam int unsigned SegBits = 65536;
  localparam int unsigned SegAw = 16;
  localparam int unsigned BaseBits = 8192;
  localparam int unsigned BaseAw = 13;
  localparam int unsigned GapWindow = 500;
  localparam logic [24:0] LimitReset = 25'd1000000;
  localparam logic [10:0] CountReset = 11'd16;
  localparam logic [0:0] RegLimit = 1'b0;
  localparam logic [0:0] RegCount = 1'b1;

  typedef struct packed {
    logic start;
    logic [9:0] index;
    logic [24:0] limit;
    logic [10:0] count;
  } ssg_job_t;
endpackage

// File: rtl/ssg_divider.sv
module ssg_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [35:0] dividend_i,
  input  logic [12:0] divisor_i,
  output logic        done_o,
  output logic [35:0] quotient_o
);
  import ssg_pkg::*;

  logic [35:0] quo_q, quo_d;
  logic [13:0] rem_q, rem_d;
  logic [12:0] div_q, div_d;
  logic [5:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [13:0] trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    div_d = div_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = {rem_q[12:0], quo_q[35]};
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      div_d = divisor_i;
      cnt_d = 6'd36;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = trial - {1'b0, div_q};
        quo_d = {quo_q[34:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[34:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quotient_o = quo_q;
endmodule

// File: rtl/ssg_core.sv
module ssg_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssg_pkg::ssg_job_t job_i,
  output logic              done_o,
  output logic [15:0]       gap_o,
  output logic              err_o
);
  import ssg_pkg::*;

  localparam logic [4:0] SIdle = 5'd0, SDiv0 = 5'd1, SDiv0W = 5'd2, SDiv1 = 5'd3,
    SDiv1W = 5'd4, SRoot = 5'd5, SCheck = 5'd6, SClrS = 5'd7, SClrB = 5'd8,
    SPrime = 5'd9, SPrimeW = 5'd10, SBase = 5'd11, SLoDiv = 5'd12, SLoW = 5'd13,
    SMark = 5'd14, SScan = 5'd15, SScanW = 5'd16, SFin = 5'd17, SSq = 5'd18;

  logic [4:0] st_q, st_d;
  logic [24:0] n_q, n_d;
  logic [10:0] cnt_q, cnt_d;
  logic [9:0] idx_q, idx_d;
  logic [25:0] start_q, start_d, end_q, end_d, top_q, top_d;
  logic [12:0] root_q, root_d;
  logic [13:0] pn_q, pn_d;
  logic [13:0] p_q, p_d, bj_q, bj_d;
  logic [25:0] j_q, j_d;
  logic [25:0] i_q, i_d;
  logic [25:0] cand_q, cand_d;
  logic [16:0] gap_q, gap_d;
  logic [16:0] ca_q, ca_d;
  logic err_q, err_d, done_q, done_d, found_q, found_d;

  logic div_start;
  logic [35:0] div_a;
  logic [12:0] div_b;
  logic div_done;
  logic [35:0] div_quo;

  logic seg_mem [SegBits];
  logic base_mem [BaseBits];
  logic seg_we, seg_wd, base_we, base_wd;
  logic [SegAw-1:0] seg_wa, seg_ra;
  logic [BaseAw-1:0] base_wa, base_ra;
  logic seg_rd_q, base_rd_q;
  logic [25:0] sq, rr;
  logic [51:0] prod;

  ssg_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_a), .divisor_i(div_b),
    .done_o(div_done), .quotient_o(div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (seg_we) seg_mem[seg_wa] <= seg_wd;
    seg_rd_q <= seg_mem[seg_ra];
    if (base_we) base_mem[base_wa] <= base_wd;
    base_rd_q <= base_mem[base_ra];
  end

  always_comb begin
    st_d = st_q; n_d = n_q; cnt_d = cnt_q; idx_d = idx_q;
    start_d = start_q; end_d = end_q; top_d = top_q; root_d = root_q; pn_d = pn_q;
    p_d = p_q; bj_d = bj_q; j_d = j_q; i_d = i_q; cand_d = cand_q; gap_d = gap_q;
    ca_d = ca_q; err_d = err_q; done_d = 1'b0; found_d = found_q;
    div_start = 1'b0; div_a = '0; div_b = {2'b00, cnt_q};
    seg_we = 1'b0; seg_wd = 1'b1; seg_wa = '0; seg_ra = '0;
    base_we = 1'b0; base_wd = 1'b1; base_wa = '0; base_ra = '0;
    rr = {13'd0, root_q} + 26'd1;
    sq = rr * rr;
    prod = '0;
    unique case (st_q)
      SIdle: begin
        if (job_i.start) begin
          n_d = job_i.limit; cnt_d = job_i.count; idx_d = job_i.index;
          err_d = 1'b0; gap_d = 17'd1;
          if (job_i.count == 11'd0 || {1'b0, job_i.index} >= job_i.count) begin
            err_d = 1'b1;
            st_d = SFin;
          end else st_d = SDiv0;
        end
      end
      SDiv0: begin
        div_start = 1'b1;
        div_a = 36'(idx_q) * 36'(n_q);
        st_d = SDiv0W;
      end
      SDiv0W: if (div_done) begin
        start_d = 26'(div_quo) + 26'd1;
        st_d = SDiv1;
      end
      SDiv1: begin
        div_start = 1'b1;
        div_a = 36'({1'b0, idx_q} + 11'd1) * 36'(n_q);
        st_d = SDiv1W;
      end
      SDiv1W: if (div_done) begin
        end_d = 26'(div_quo);
        top_d = 26'(div_quo) + 26'(GapWindow);
        root_d = '0;
        st_d = SRoot;
      end
      SRoot: begin
        if (sq <= {1'b0, n_q} && root_q != 13'h1fff) root_d = root_q + 13'd1;
        else begin
          pn_d = {1'b0, root_q} + 14'd1;
          st_d = SCheck;
        end
      end
      SCheck: begin
        if ((27'(end_q) + 27'd1 + 27'(GapWindow) - 27'(start_q)) > 27'(SegBits)
            || (pn_q + 14'd1) > 14'(BaseBits)) begin
          err_d = 1'b1;
          st_d = SFin;
        end else begin
          j_d = '0;
          st_d = SClrS;
        end
      end
      SClrS: begin
        seg_we = 1'b1; seg_wd = 1'b0; seg_wa = j_q[SegAw-1:0];
        j_d = j_q + 26'd1;
        if (j_q == 26'(SegBits - 1)) begin
          bj_d = '0;
          st_d = SClrB;
        end
      end
      SClrB: begin
        base_we = 1'b1; base_wd = 1'b0; base_wa = bj_q[BaseAw-1:0];
        bj_d = bj_q + 14'd1;
        if (bj_q == 14'(BaseBits - 1)) begin
          p_d = 14'd2;
          st_d = SPrime;
        end
      end
      SPrime: begin
        if (p_q > pn_q) begin
          i_d = (start_q > 26'd3) ? start_q : 26'd3;
          st_d = SScan;
        end else begin
          base_ra = p_q[BaseAw-1:0];
          st_d = SPrimeW;
        end
      end
      SPrimeW: begin
        if (base_rd_q) begin
          p_d = p_q + 14'd1;
          st_d = SPrime;
        end else begin
          bj_d = p_q + p_q;
          st_d = SBase;
        end
      end
      SBase: begin
        if (bj_q > pn_q) st_d = SLoDiv;
        else begin
          base_we = 1'b1; base_wa = bj_q[BaseAw-1:0];
          bj_d = bj_q + p_q;
        end
      end
      SLoDiv: begin
        div_start = 1'b1;
        div_b = 13'(p_q);
        div_a = 36'(start_q + 26'(p_q) - 26'd1);
        st_d = SLoW;
      end
      SLoW: if (div_done) begin
        prod = 52'(div_quo[25:0]) * 52'(p_q);
        j_d = 26'(prod);
        st_d = SSq;
      end
      SSq: begin
        prod = 52'(p_q) * 52'(p_q);
        if (26'(prod) > j_q) j_d = 26'(prod);
        st_d = SMark;
      end
      SMark: begin
        if (j_q > top_q) begin
          p_d = p_q + 14'd1;
          st_d = SPrime;
        end else begin
          seg_we = 1'b1;
          seg_wa = SegAw'(j_q - start_q);
          j_d = j_q + 26'(p_q);
        end
      end
      SScan: begin
        if (i_q > end_q) st_d = SFin;
        else begin
          seg_ra = SegAw'(i_q - start_q);
          found_d = 1'b0;
          cand_d = i_q;
          ca_d = '0;
          st_d = SScanW;
        end
      end
      SScanW: begin
        if (!found_d && cand_q == i_q && ca_q == 17'd0) begin
          if (seg_rd_q) begin
            i_d = i_q + 26'd1;
            st_d = SScan;
          end else begin
            ca_d = 17'd1;
            cand_d = i_q + 26'd2;
            seg_ra = SegAw'(i_q + 26'd2 - start_q);
          end
        end else begin
          if (cand_q > top_q) begin
            i_d = i_q + 26'd1;
            st_d = SScan;
          end else if (ca_q == 17'd1) begin
            ca_d = 17'd2;
            seg_ra = SegAw'(cand_q - start_q);
          end else if (!seg_rd_q) begin
            if (17'(cand_q - i_q) > gap_q) gap_d = 17'(cand_q - i_q);
            i_d = i_q + 26'd1;
            st_d = SScan;
          end else begin
            cand_d = cand_q + 26'd2;
            ca_d = 17'd1;
          end
        end
      end
      SFin: begin
        done_d = 1'b1;
        st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      done_q <= 1'b0;
    end else begin
      st_q <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; cnt_q <= cnt_d; idx_q <= idx_d; start_q <= start_d; end_q <= end_d;
    top_q <= top_d; root_q <= root_d; pn_q <= pn_d; p_q <= p_d; bj_q <= bj_d;
    j_q <= j_d; i_q <= i_d; cand_q <= cand_d; gap_q <= gap_d; ca_q <= ca_d;
    err_q <= err_d; found_q <= found_d;
  end

  assign done_o = done_q;
  assign err_o = err_q;
  assign gap_o = err_q ? 16'd0 : ((gap_q > 17'd65535) ? 16'hffff : gap_q[15:0]);

`ifndef SYNTHESIS
  a_done_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(st_q) == SFin) else $error("done without finish");
  a_gap_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !err_q) |-> gap_o != 16'd0) else $error("zero gap");
  a_err_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && err_q) |-> gap_o == 16'd0) else $error("error gap");
`endif
endmodule

// File: rtl/segmented_sieve_max_prime_gap.sv
// Segmented sieve prime-gap engine. A configuration word writes the total
// limit (index 0) or the worker count (index 1); writes are taken only when
// the block is idle. A job word carries a worker index. The block computes
// the segment bounds with a shared 36-step serial divider, finds the integer
// square root one step a cycle, clears the 65536-entry segment bitmap and the
// 8192-entry base bitmap one entry a cycle, sieves base primes, marks
// composites one multiple a cycle, and scans the segment bitmap. Out of range
// jobs finish with range_error set and a zero gap. Only one job is in
// flight; in_ready_o is low while it runs. The result word sits in an output
// register until taken; a new job may be accepted meanwhile, and a job that
// finishes while that register is still held waits in the core, keeping
// in_ready_o low, until it frees. Reset returns the configuration to a limit
// of 1000000 and 16 workers and empties the output register.
module segmented_sieve_max_prime_gap (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [24:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [9:0]  worker_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] max_gap_o,
  output logic        range_error_o
);
  import ssg_pkg::*;

  logic [24:0] limit_q;
  logic [10:0] count_q;
  logic busy_q, ov_q, res_q;
  logic [15:0] gap_q;
  logic err_q;
  ssg_job_t job;
  logic done;
  logic move;
  logic [15:0] cgap;
  logic cerr;

  assign in_ready_o = !busy_q;
  assign cfg_ready_o = !busy_q;
  assign job.start = in_valid_i && !busy_q;
  assign job.index = worker_index_i;
  assign job.limit = limit_q;
  assign job.count = count_q;
  assign move = (done || res_q) && (!ov_q || out_ready_i);

  ssg_core u_core (.clk_i, .rst_ni, .job_i(job), .done_o(done), .gap_o(cgap), .err_o(cerr));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
      count_q <= CountReset;
      busy_q <= 1'b0;
      ov_q <= 1'b0;
      res_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == RegLimit) limit_q <= cfg_data_i;
        else count_q <= cfg_data_i[10:0];
      end
      if (job.start) busy_q <= 1'b1;
      else if (move) busy_q <= 1'b0;
      if (move) res_q <= 1'b0;
      else if (done) res_q <= 1'b1;
      if (move) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      gap_q <= cgap;
      err_q <= cerr;
    end
  end

  assign out_valid_o = ov_q;
  assign max_gap_o = gap_q;
  assign range_error_o = err_q;

`ifndef SYNTHESIS
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !job.start) else $error("start while busy");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> busy_q) else $error("done while idle");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && err_q) |-> gap_q == 16'd0) else $error("error with gap");
`endif
endmodule

// File: dv/segmented_sieve_max_prime_gap_test.sv
module segmented_sieve_max_prime_gap_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ssg_pkg::*;

  typedef struct packed {
    logic [15:0] max_gap;
    logic        range_error;
  } gap_word_t;

  localparam int unsigned StallLimit = 2000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = RegLimit;
  logic [24:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [9:0]  worker_index_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] max_gap_o;
  logic        range_error_o;

  logic [24:0] limit_q = LimitReset;
  logic [10:0] count_q = CountReset;
  bit          seg_marks[SegBits];
  bit          base_marks[BaseBits];

  logic [9:0]  pending_indexes[$];
  gap_word_t   gaps_due[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          idle_cycles = 0;
  int          errors = 0;

  segmented_sieve_max_prime_gap i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic gap_word_t sieve_gap(logic [9:0] index);
    gap_word_t   res;
    longint unsigned lim, cnt, first, last, top, span, root, k, m, lo, gap;
    lim = limit_q;
    cnt = count_q;
    res = '{max_gap: '0, range_error: 1'b1};
    foreach (seg_marks[a]) seg_marks[a] = 1'b0;
    foreach (base_marks[a]) base_marks[a] = 1'b0;
    if (cnt == 0 || index >= cnt) return res;
    first = index * lim / cnt + 1;
    last = (index + 1) * lim / cnt;
    top = last + GapWindow;
    span = last + 1 + GapWindow - first;
    root = 0;
    while ((root + 1) * (root + 1) <= lim) root++;
    root = root + 1;
    if (span > SegBits || root + 1 > BaseBits) return res;
    for (k = 2; k <= root; k++) begin
      if (base_marks[k]) continue;
      for (m = k + k; m <= root; m += k) base_marks[m] = 1'b1;
      lo = (first + k - 1) / k * k;
      if (k * k > lo) lo = k * k;
      for (m = lo; m <= top; m += k) seg_marks[m - first] = 1'b1;
    end
    gap = 1;
    for (k = (first > 3) ? first : 3; k <= last; k++) begin
      if (seg_marks[k - first]) continue;
      for (m = k + 2; m <= top; m += 2) begin
        if (seg_marks[m - first]) continue;
        if (m - k > gap) gap = m - k;
        break;
      end
    end
    res.max_gap = (gap > 65535) ? 16'hFFFF : gap[15:0];
    res.range_error = 1'b0;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (pending_indexes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        worker_index_i <= pending_indexes.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    gap_word_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) gaps_due.push_back(sieve_gap(worker_index_i));
      if (out_valid_o && out_ready_i) begin
        if (gaps_due.size() == 0) begin
          $error("Result word with nothing outstanding: max_gap %0d range_error %0d",
                 max_gap_o, range_error_o);
          errors++;
        end else begin
          want = gaps_due.pop_front();
          if (max_gap_o !== want.max_gap) begin
            $error("max_gap: expected %0d, got %0d", want.max_gap, max_gap_o);
            errors++;
          end
          if (range_error_o !== want.range_error) begin
            $error("range_error: expected %0d, got %0d", want.range_error, range_error_o);
            errors++;
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= StallLimit) begin
        $display("** segmented_sieve_max_prime_gap: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic write_reg(logic [0:0] index, logic [24:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (index == RegLimit) limit_q = value;
    else count_q = value[10:0];
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending_indexes.size() > 0 || gaps_due.size() > 0 || in_valid_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic run_jobs(logic [24:0] lim, logic [10:0] cnt, int jobs);
    logic [9:0] index;
    write_reg(RegLimit, lim);
    write_reg(RegCount, cnt);
    for (int n = 0; n < jobs; n++) begin
      if (cnt != 0 && $urandom_range(99) < 80) index = 10'($urandom_range(cnt - 1));
      else index = 10'($urandom_range(1023));
      pending_indexes.push_back(index);
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    pending_indexes = '{10'd0, 10'd15, 10'd16, 10'd1023};
    drain();
    write_reg(RegLimit, 25'd4);
    write_reg(RegCount, 11'd1);
    pending_indexes = '{10'd0, 10'd1};
    drain();
    write_reg(RegLimit, 25'd0);
    write_reg(RegCount, 11'd5);
    pending_indexes = '{10'd0, 10'd4};
    drain();
    write_reg(RegLimit, 25'd100);
    write_reg(RegCount, 11'd0);
    pending_indexes = '{10'd0, 10'd1023};
    drain();
    write_reg(RegLimit, 25'h1FFFFFF);
    write_reg(RegCount, 11'd1024);
    pending_indexes = '{10'd1023, 10'd0};
    drain();
    write_reg(RegLimit, 25'd16777216);
    pending_indexes = '{10'd512};
    drain();
    write_reg(RegLimit, 25'd1000000);
    write_reg(RegCount, 11'd1);
    pending_indexes = '{10'd0};
    drain();
    write_reg(RegCount, 11'h7FF);
    pending_indexes = '{10'd1023, 10'd3};
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? 65 : 0;
      recv_stall_pct = (phase == 2) ? 65 : 0;
      if (phase == 3) recv_stall_pct = 24;
      if (phase == 3) send_idle_pct = 24;
      for (int b = 0; b < 3; b++) begin
        run_jobs(25'($urandom_range(30000, 4)), 11'($urandom_range(64, 1)), 8);
      end
    end

    if (errors == 0) begin
      $display("** segmented_sieve_max_prime_gap: PASSED **");
    end else begin
      $display("** segmented_sieve_max_prime_gap: FAILED **");
    end
    $finish;
  end
endmodule
